>>> sv/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, latencies, types and rounding helpers for the look-at
// view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int UNIT_W     = 32;   // Q2.30 unit vector component
  localparam int AXIS_W     = 16;   // Q2.14 axis output
  localparam int POS_W      = 32;   // Q16.16 coordinate
  localparam int WIDE_W     = 64;   // products and cross terms
  localparam int FRAC_U     = 30;   // fraction bits of a unit component
  localparam int MAG_W      = 30;   // normalized magnitude width
  localparam int SUM_W      = 62;   // sum of three squared magnitudes
  localparam int ROOT_W     = 31;   // integer square root of the sum
  localparam int SQRT_STEPS = 31;   // one root bit per stage
  localparam int DIV_STEPS  = 31;   // one quotient bit per stage
  localparam int GRP_W      = 8;    // leading-one search group size
  localparam int NORM_LAT   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
  localparam int CROSS_LAT  = 2;
  localparam int AXIS_MAX   = 16384;

  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [POS_W-1:0]  pos_t;

  // Q2.30 -> Q2.14, round half up, clamp to +/- one
  function automatic axis_t axis_round(unit_t v);
    logic signed [UNIT_W:0]   t;
    logic signed [AXIS_W:0]   r;
    axis_t                    res;
    t = (UNIT_W+1)'(v) + (UNIT_W+1)'(32768);
    r = (AXIS_W+1)'(t >>> 16);
    if (r > (AXIS_W+1)'(AXIS_MAX)) begin
      res = AXIS_W'(AXIS_MAX);
    end else if (r < -(AXIS_W+1)'(AXIS_MAX)) begin
      res = -AXIS_W'(AXIS_MAX);
    end else begin
      res = r[AXIS_W-1:0];
    end
    return res;
  endfunction

  // -dot in Q18.46 wide form -> Q16.16, round half up, saturate
  function automatic pos_t shift_round(wide_t dot);
    logic signed [WIDE_W:0]          n;
    logic signed [WIDE_W-FRAC_U:0]   r;
    pos_t                            res;
    n = (WIDE_W+1)'(dot);
    n = -n + ((WIDE_W+1)'(1) <<< (FRAC_U - 1));
    r = (WIDE_W-FRAC_U+1)'(n >>> FRAC_U);
    if (r > (WIDE_W-FRAC_U+1)'(32'sh7fffffff)) begin
      res = 32'sh7fffffff;
    end else if (r < (WIDE_W-FRAC_U+1)'(-33'sh80000000)) begin
      res = 32'sh80000000;
    end else begin
      res = r[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> sv/lav_delay.sv
// ----------------------------------------------------------------------------
// lav_delay
// Shift line that keeps payload aligned with the pipeline; advances on en.
// ----------------------------------------------------------------------------
module lav_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  // shift one tap per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

>>> sv/lav_cross.sv
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product of Q2.30 vectors: registered products, then
// registered differences in Q4.60.
// ----------------------------------------------------------------------------
module lav_cross (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lav_pkg::unit_t a [3],
  input  lav_pkg::unit_t b [3],
  output logic           out_valid,
  output lav_pkg::wide_t r [3]
);
  import lav_pkg::*;

  wide_t prod [6];
  logic  vld1;

  // product stage
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= a[1] * b[2];
      prod[1] <= a[2] * b[1];
      prod[2] <= a[2] * b[0];
      prod[3] <= a[0] * b[2];
      prod[4] <= a[0] * b[1];
      prod[5] <= a[1] * b[0];
    end
  end

  // difference stage
  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= prod[0] - prod[1];
      r[1] <= prod[2] - prod[3];
      r[2] <= prod[4] - prod[5];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld1      <= in_valid;
      out_valid <= vld1;
    end
  end

endmodule

>>> sv/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer. Common shift puts the largest magnitude in
// [2^29, 2^30), squares are summed, a bit-per-stage square root gives the
// length, and a bit-per-stage restoring divider forms each Q2.30 component.
// A zero vector gives zero.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int IN_W = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic signed [IN_W-1:0] v [3],
  output logic                   out_valid,
  output lav_pkg::unit_t         u [3]
);
  import lav_pkg::*;

  localparam int NG = (IN_W + GRP_W - 1) / GRP_W;
  localparam int OW = NG * GRP_W;
  localparam int PW = $clog2(OW);
  localparam int GW = $clog2(GRP_W);

  // stage 1: sign and magnitude
  logic [IN_W-1:0] s1_mag [3];
  logic [2:0]      s1_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_neg[i] <= v[i][IN_W-1];
        s1_mag[i] <= v[i][IN_W-1] ? IN_W'(-v[i]) : IN_W'(v[i]);
      end
    end
  end

  // stage 2: per-group leading one of the OR of all magnitudes
  logic [OW-1:0]   s2_or;
  logic [NG-1:0]   grp_nz;
  logic [GW-1:0]   grp_pos [NG];
  logic [NG-1:0]   s2_nz;
  logic [GW-1:0]   s2_pos [NG];
  logic [IN_W-1:0] s2_mag [3];
  logic [2:0]      s2_neg;

  assign s2_or = OW'(s1_mag[0] | s1_mag[1] | s1_mag[2]);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nz[g]  = |s2_or[g*GRP_W +: GRP_W];
      grp_pos[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        if (s2_or[g*GRP_W + b]) begin
          grp_pos[g] = GW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nz  <= grp_nz;
      s2_pos <= grp_pos;
      s2_mag <= s1_mag;
      s2_neg <= s1_neg;
    end
  end

  // stage 3: highest nonzero group gives the leading-one position
  logic [PW-1:0]   msb_pos;
  logic [PW-1:0]   s3_p;
  logic            s3_zero;
  logic [IN_W-1:0] s3_mag [3];
  logic [2:0]      s3_neg;

  always_comb begin
    msb_pos = '0;
    for (int g = 0; g < NG; g++) begin
      if (s2_nz[g]) begin
        msb_pos = PW'(g * GRP_W) + PW'(s2_pos[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_p    <= msb_pos;
      s3_zero <= ~|s2_nz;
      s3_mag  <= s2_mag;
      s3_neg  <= s2_neg;
    end
  end

  // stage 4: common shift so the leading one lands on bit 29
  logic [IN_W-1:0]  shifted [3];
  logic [MAG_W-1:0] s4_m [3];
  logic [2:0]       s4_neg;
  logic             s4_zero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s3_p >= PW'(MAG_W)) begin
        shifted[i] = s3_mag[i] >> (s3_p - PW'(MAG_W - 1));
      end else begin
        shifted[i] = s3_mag[i] << (PW'(MAG_W - 1) - s3_p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_m[i] <= shifted[i][MAG_W-1:0];
      end
      s4_neg  <= s3_neg;
      s4_zero <= s3_zero;
    end
  end

  // stage 5: squares
  logic [2*MAG_W-1:0] s5_sq [3];
  logic [MAG_W-1:0]   s5_m [3];
  logic [2:0]         s5_neg;
  logic               s5_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq[i] <= s4_m[i] * s4_m[i];
      end
      s5_m    <= s4_m;
      s5_neg  <= s4_neg;
      s5_zero <= s4_zero;
    end
  end

  // stage 6 and square root steps: root bit K resolved in each stage
  logic [SUM_W-1:0]  sq_rem  [SQRT_STEPS+1];
  logic [ROOT_W-1:0] sq_root [SQRT_STEPS+1];
  logic [MAG_W-1:0]  sq_m    [SQRT_STEPS+1][3];
  logic [2:0]        sq_neg  [SQRT_STEPS+1];
  logic              sq_zero [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    logic [WIDE_W-1:0] trial;
    int                kb;
    if (en) begin
      sq_rem[0]  <= SUM_W'(s5_sq[0]) + SUM_W'(s5_sq[1]) + SUM_W'(s5_sq[2]);
      sq_root[0] <= '0;
      sq_m[0]    <= s5_m;
      sq_neg[0]  <= s5_neg;
      sq_zero[0] <= s5_zero;
      for (int j = 0; j < SQRT_STEPS; j++) begin
        kb    = SQRT_STEPS - 1 - j;
        trial = (WIDE_W'(sq_root[j]) << (kb + 1)) + (WIDE_W'(1) << (2 * kb));
        if (WIDE_W'(sq_rem[j]) >= trial) begin
          sq_rem[j+1]  <= SUM_W'(WIDE_W'(sq_rem[j]) - trial);
          sq_root[j+1] <= sq_root[j] | (ROOT_W'(1) << kb);
        end else begin
          sq_rem[j+1]  <= sq_rem[j];
          sq_root[j+1] <= sq_root[j];
        end
        sq_m[j+1]    <= sq_m[j];
        sq_neg[j+1]  <= sq_neg[j];
        sq_zero[j+1] <= sq_zero[j];
      end
    end
  end

  // divider prep and restoring steps: quotient bit K resolved per stage
  logic [SUM_W-1:0]  dv_rem  [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dv_q    [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dv_len  [DIV_STEPS+1];
  logic [2:0]        dv_neg  [DIV_STEPS+1];
  logic              dv_zero [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    logic [SUM_W-1:0] dsor;
    int               kb;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (SUM_W'(sq_m[SQRT_STEPS][i]) << FRAC_U)
                        + SUM_W'(sq_root[SQRT_STEPS] >> 1);
        dv_q[0][i]   <= '0;
      end
      dv_len[0]  <= sq_root[SQRT_STEPS];
      dv_neg[0]  <= sq_neg[SQRT_STEPS];
      dv_zero[0] <= sq_zero[SQRT_STEPS];
      for (int j = 0; j < DIV_STEPS; j++) begin
        kb   = DIV_STEPS - 1 - j;
        dsor = SUM_W'(dv_len[j]) << kb;
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= dsor) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - dsor;
            dv_q[j+1][i]   <= dv_q[j][i] | (ROOT_W'(1) << kb);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_len[j+1]  <= dv_len[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
      end
    end
  end

  // final stage: apply sign, force zero vector
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_zero[DIV_STEPS]) begin
          u[i] <= '0;
        end else if (dv_neg[DIV_STEPS][i]) begin
          u[i] <= -UNIT_W'(dv_q[DIV_STEPS][i]);
        end else begin
          u[i] <= UNIT_W'(dv_q[DIV_STEPS][i]);
        end
      end
    end
  end

  // valid bits
  logic [NORM_LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NORM_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[NORM_LAT-1];

endmodule

>>> sv/look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Right-handed look-at view matrix in fixed point: back, right and derived
// up axes in Q2.14 and the three translations in Q16.16.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   eye, focus, up (9 x Q16.16)
//  m_axis    out  right, upward, back axes (9 x Q2.14), shifts (3 x Q16.16)
//
//  One view per cycle sustained while the output is taken; the depth is set by two
//  normalizers in series (70 stages each: 31 square-root steps and 31 divider steps).
//  Synchronous active-high reset clears all valid bits; data is not reset.
//  The whole pipeline advances when the output register is empty or taken;
//  a stall freezes every stage in place.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // eye_x, eye_y, eye_z, focus_x, focus_y, focus_z, up_x, up_y, up_z
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // right_x/y/z, upward_x/y/z, back_x/y/z (16 b each), shift_x/y/z (32 b)
  output logic [239:0] m_tdata
);
  import lav_pkg::*;

  localparam int EYE_DLY = 2 * NORM_LAT + 2 * CROSS_LAT;
  localparam int Z_DLY   = CROSS_LAT + NORM_LAT;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // input stage: eye minus focus
  pos_t                  eye_r [3];
  logic signed [POS_W:0] dir_r [3];
  pos_t                  up_r  [3];
  logic                  v0;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye_r[i] <= s_tdata[i*POS_W +: POS_W];
        up_r[i]  <= s_tdata[(6+i)*POS_W +: POS_W];
        dir_r[i] <= (POS_W+1)'($signed(s_tdata[i*POS_W +: POS_W]))
                    - (POS_W+1)'($signed(s_tdata[(3+i)*POS_W +: POS_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= s_tvalid;
    end
  end

  // back axis and normalized up
  unit_t z [3];
  unit_t nup [3];
  logic  vz;
  logic  vup;

  lav_norm #(.IN_W(POS_W + 1)) u_norm_z (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .v(dir_r),
    .out_valid(vz), .u(z)
  );

  lav_norm #(.IN_W(POS_W)) u_norm_up (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0), .v(up_r),
    .out_valid(vup), .u(nup)
  );

  // right axis, unnormalized then normalized
  wide_t xw [3];
  logic  vxw;
  unit_t x [3];
  logic  vx;

  // both normalizers run in lockstep, so their valids coincide
  lav_cross u_cross_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(vz && vup), .a(nup), .b(z),
    .out_valid(vxw), .r(xw)
  );

  lav_norm #(.IN_W(WIDE_W)) u_norm_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(vxw), .v(xw),
    .out_valid(vx), .u(x)
  );

  // back axis held until the right axis is ready
  logic [3*UNIT_W-1:0] z_flat, zd1_flat, zd2_flat;
  unit_t               zd1 [3];

  assign z_flat = {z[2], z[1], z[0]};

  lav_delay #(.WIDTH(3*UNIT_W), .DEPTH(Z_DLY)) u_dly_z1 (
    .clk(clk), .en(en), .d(z_flat), .q(zd1_flat)
  );

  lav_delay #(.WIDTH(3*UNIT_W), .DEPTH(CROSS_LAT)) u_dly_z2 (
    .clk(clk), .en(en), .d(zd1_flat), .q(zd2_flat)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zd1[i] = zd1_flat[i*UNIT_W +: UNIT_W];
    end
  end

  // derived up axis
  wide_t yw [3];
  logic  vyw;

  lav_cross u_cross_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(vx), .a(zd1), .b(x),
    .out_valid(vyw), .r(yw)
  );

  // right axis and eye aligned with the derived up axis
  logic [3*UNIT_W-1:0] x_flat, xd_flat;
  logic [3*POS_W-1:0]  eye_flat, eyed_flat;

  assign x_flat   = {x[2], x[1], x[0]};
  assign eye_flat = {eye_r[2], eye_r[1], eye_r[0]};

  lav_delay #(.WIDTH(3*UNIT_W), .DEPTH(CROSS_LAT)) u_dly_x (
    .clk(clk), .en(en), .d(x_flat), .q(xd_flat)
  );

  lav_delay #(.WIDTH(3*POS_W), .DEPTH(EYE_DLY)) u_dly_eye (
    .clk(clk), .en(en), .d(eye_flat), .q(eyed_flat)
  );

  // round derived up axis to Q2.30, gather all three axes
  unit_t ax_x [3];
  unit_t ax_y [3];
  unit_t ax_z [3];
  pos_t  eye_y [3];
  logic  vy;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ax_y[i]  <= UNIT_W'((yw[i] + (WIDE_W'(1) <<< (FRAC_U - 1))) >>> FRAC_U);
        ax_x[i]  <= xd_flat[i*UNIT_W +: UNIT_W];
        ax_z[i]  <= zd2_flat[i*UNIT_W +: UNIT_W];
        eye_y[i] <= eyed_flat[i*POS_W +: POS_W];
      end
    end
  end

  // products for the translations, axis rounding
  wide_t prd [3][3];
  axis_t ax1 [9];
  logic  vp1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prd[0][i] <= ax_x[i] * eye_y[i];
        prd[1][i] <= ax_y[i] * eye_y[i];
        prd[2][i] <= ax_z[i] * eye_y[i];
        ax1[i]    <= axis_round(ax_x[i]);
        ax1[3+i]  <= axis_round(ax_y[i]);
        ax1[6+i]  <= axis_round(ax_z[i]);
      end
    end
  end

  // dot sums
  wide_t dot [3];
  axis_t ax2 [9];
  logic  vp2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        dot[a] <= prd[a][0] + prd[a][1] + prd[a][2];
      end
      ax2 <= ax1;
    end
  end

  // output register: round and saturate translations, pack the beat
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        m_tdata[k*AXIS_W +: AXIS_W] <= ax2[k];
      end
      for (int a = 0; a < 3; a++) begin
        m_tdata[9*AXIS_W + a*POS_W +: POS_W] <= shift_round(dot[a]);
      end
    end
  end

  // valid bits of the tail stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vy       <= 1'b0;
      vp1      <= 1'b0;
      vp2      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vy       <= vyw;
      vp1      <= vy;
      vp2      <= vp1;
      m_tvalid <= vp2;
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Look-at view matrix unit testbench: streams eye/focus/up views into the
// unit, predicts every axis and translation in bit-true fixed point and
// checks each output beat in order, with random gaps and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [63:0] w64_t;
  typedef w64_t vec3_t [3];

  // input beat, eye_x in the lowest bits
  typedef struct packed {
    logic signed [31:0] up_z, up_y, up_x;
    logic signed [31:0] focus_z, focus_y, focus_x;
    logic signed [31:0] eye_z, eye_y, eye_x;
  } view_t;

  // output beat, right_x in the lowest bits
  typedef struct packed {
    logic signed [31:0] shift_z, shift_y, shift_x;
    logic signed [15:0] back_z, back_y, back_x;
    logic signed [15:0] upward_z, upward_y, upward_x;
    logic signed [15:0] right_z, right_y, right_x;
  } matrix_t;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 600;
  localparam int DRAIN_WAIT  = 300;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready;
  logic [287:0] s_tdata;
  logic [239:0] m_tdata;

  matrix_t expected_mats[$];
  int      errors, views_sent, mats_checked, idle_cycles;
  bit      long_hold_req;
  bit      sink_busy_mode;

  look_at_view_matrix_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b   = 64'h1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Q2.30 unit vector; zero vector stays zero
  function automatic vec3_t unit_vec(vec3_t v);
    logic [63:0] mag [3];
    logic        neg [3];
    logic [63:0] mx, sum, len, q;
    vec3_t       u;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i][63];
      mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (mx == 0) return u;
    while (mx >= (64'h1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'h1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q    = ((mag[i] << 30) + (len >> 1)) / len;
      u[i] = neg[i] ? -w64_t'(q) : w64_t'(q);
    end
    return u;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  // floor((t + 2^(s-1)) / 2^s)
  function automatic w64_t round_shift(w64_t t, int s);
    return (t + (w64_t'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] to_axis(w64_t v);
    w64_t r;
    r = round_shift(v, 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic logic signed [31:0] to_shift(vec3_t a, vec3_t eye);
    w64_t r;
    r = round_shift(-(a[0] * eye[0] + a[1] * eye[1] + a[2] * eye[2]), 30);
    if (r > 64'sh7fffffff) r = 64'sh7fffffff;
    if (r < -64'sh80000000) r = -64'sh80000000;
    return r[31:0];
  endfunction

  function automatic matrix_t view_matrix(view_t v);
    vec3_t eye, dir, upv, back, right, upw, t;
    matrix_t m;
    eye = '{w64_t'(v.eye_x), w64_t'(v.eye_y), w64_t'(v.eye_z)};
    dir = '{eye[0] - w64_t'(v.focus_x), eye[1] - w64_t'(v.focus_y),
            eye[2] - w64_t'(v.focus_z)};
    upv = '{w64_t'(v.up_x), w64_t'(v.up_y), w64_t'(v.up_z)};
    back  = unit_vec(dir);
    right = unit_vec(cross3(unit_vec(upv), back));
    t     = cross3(back, right);
    for (int i = 0; i < 3; i++) upw[i] = round_shift(t[i], 30);
    m.right_x  = to_axis(right[0]); m.right_y  = to_axis(right[1]);
    m.right_z  = to_axis(right[2]);
    m.upward_x = to_axis(upw[0]);   m.upward_y = to_axis(upw[1]);
    m.upward_z = to_axis(upw[2]);
    m.back_x   = to_axis(back[0]);  m.back_y   = to_axis(back[1]);
    m.back_z   = to_axis(back[2]);
    m.shift_x  = to_shift(right, eye);
    m.shift_y  = to_shift(upw, eye);
    m.shift_z  = to_shift(back, eye);
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input beat, compare on output beat
  // --------------------------------------------------------------------------
  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    matrix_t e, a;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_mats.push_back(view_matrix(view_t'(s_tdata)));
      if (m_tvalid && m_tready) begin
        a = matrix_t'(m_tdata);
        if (expected_mats.size() == 0) begin
          $error("output beat with no view pending");
          errors++;
        end else begin
          e = expected_mats.pop_front();
          mats_checked++;
          check_field("right_x", e.right_x, a.right_x);
          check_field("right_y", e.right_y, a.right_y);
          check_field("right_z", e.right_z, a.right_z);
          check_field("upward_x", e.upward_x, a.upward_x);
          check_field("upward_y", e.upward_y, a.upward_y);
          check_field("upward_z", e.upward_z, a.upward_z);
          check_field("back_x", e.back_x, a.back_x);
          check_field("back_y", e.back_y, a.back_y);
          check_field("back_z", e.back_z, a.back_z);
          check_field("shift_x", e.shift_x, a.shift_x);
          check_field("shift_y", e.shift_y, a.shift_y);
          check_field("shift_z", e.shift_z, a.shift_z);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sink: random ready gaps, optional long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end
      m_tready <= 1'b1;
      @(negedge clk);
      if (sink_busy_mode && $urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Source
  // --------------------------------------------------------------------------
  bit src_gaps;

  task automatic send_view(view_t v);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    views_sent++;
    if (src_gaps && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      3: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      4: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return 32'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic view_t rand_view();
    view_t v;
    int    k;
    v = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom()};
    if ($urandom_range(0, 3) != 0) begin
      v.eye_x = rand_coord(); v.eye_y = rand_coord(); v.eye_z = rand_coord();
      v.focus_x = rand_coord(); v.focus_y = rand_coord(); v.focus_z = rand_coord();
      v.up_x = rand_coord(); v.up_y = rand_coord(); v.up_z = rand_coord();
    end
    k = $urandom_range(0, 19);
    // occasional degenerate geometry
    if (k == 0) begin
      v.focus_x = v.eye_x; v.focus_y = v.eye_y; v.focus_z = v.eye_z;
    end else if (k == 1) begin
      v.up_x = 0; v.up_y = 0; v.up_z = 0;
    end else if (k == 2) begin
      v.up_x = v.eye_x - v.focus_x; v.up_y = v.eye_y - v.focus_y;
      v.up_z = v.eye_z - v.focus_z;
    end
    return v;
  endfunction

  function automatic view_t make_view(int ex, int ey, int ez, int fx, int fy, int fz,
                                      int ux, int uy, int uz);
    view_t v;
    v.eye_x = ex; v.eye_y = ey; v.eye_z = ez;
    v.focus_x = fx; v.focus_y = fy; v.focus_z = fz;
    v.up_x = ux; v.up_y = uy; v.up_z = uz;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  localparam int ONE = 1 << 16;
  localparam int MX  = 32'h7fffffff;
  localparam int MN  = 32'h80000000;

  task automatic test_directed();
    src_gaps = 1'b0;
    sink_busy_mode = 1'b0;
    // canonical camera, identity-like axes
    send_view(make_view(0, 0, ONE, 0, 0, 0, 0, ONE, 0));
    send_view(make_view(3 * ONE, 2 * ONE, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    // eye equal to focus
    send_view(make_view(7 * ONE, -ONE, 4, 7 * ONE, -ONE, 4, 0, ONE, 0));
    // zero up vector
    send_view(make_view(ONE, ONE, ONE, 0, 0, 0, 0, 0, 0));
    // up parallel and anti-parallel to the view direction
    send_view(make_view(0, 5 * ONE, 0, 0, 0, 0, 0, ONE, 0));
    send_view(make_view(0, 5 * ONE, 0, 0, 0, 0, 0, -3, 0));
    // coordinate extremes, translation saturation
    send_view(make_view(MX, MX, MX, MN, MN, MN, MX, MX, MX));
    send_view(make_view(MN, MN, MN, MX, MX, MX, MN, MN, MN));
    send_view(make_view(MX, MN, MX, 0, 0, 0, MN, MX, 0));
    send_view(make_view(MN, 0, 0, MX, 0, 0, 0, 0, MX));
    send_view(make_view(MX, 0, 0, MN, 0, 0, 0, MN, 0));
    send_view(make_view(MX, MX, MX, MX, MX, MX, MX, MX, MX));
    send_view(make_view(-1, -1, -1, 0, 0, 0, -1, 0, 1));
    send_view(make_view(1, 0, 0, 0, 0, 0, 0, 1, 0));
    send_view(make_view(0, 0, -1, 0, 0, 0, 1, 1, 1));
    send_view(make_view(MX, MX, 0, 0, 0, 0, 0, 0, MN));
    send_view(make_view(-5 * ONE, 9 * ONE, -2 * ONE, ONE, ONE, ONE, 1, MX, -1));
    send_view(make_view(0, 0, 0, 0, 0, -ONE, MN, MN, MN));
    go_idle();
  endtask

  task automatic test_random(int n);
    src_gaps = 1'b1;
    for (int i = 0; i < n; i++) begin
      // alternate stretches with and without idling
      if (i % 60 == 0) begin
        sink_busy_mode = (i / 60) % 3 != 0;
        src_gaps       = (i / 60) % 3 != 1;
      end
      send_view(rand_view());
    end
    go_idle();
  endtask

  task automatic test_backpressure(int n);
    src_gaps = 1'b0;
    sink_busy_mode = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < n; i++) send_view(rand_view());
    go_idle();
  endtask

  initial begin
    errors = 0; views_sent = 0; mats_checked = 0;
    long_hold_req = 1'b0; sink_busy_mode = 1'b0; src_gaps = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure(200);
    test_random(240);

    while (expected_mats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d views (directed degenerate cases, random and long stall),",
             views_sent);
    $display("%0d matrices checked, %0d field mismatches.", mats_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
